// File: design/bookmark_position_table_core_defines.svh
// Assertion macros shared by the bookmark table RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef BOOKMARK_POSITION_TABLE_CORE_DEFINES_SVH
`define BOOKMARK_POSITION_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bpt_pkg.sv
// Package for the bookmark position table: command and status codes,
// default sizes and label folding constants. No dependencies.
`default_nettype none

package bpt_pkg;

  localparam int MARK_ENTRIES_DEF = 32;
  localparam int POS_BITS_DEF     = 24;
  localparam int COL_BITS_DEF     = 16;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int LABEL_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_GOTO   = 2'd1,
    CMD_UPDATE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  localparam logic [LABEL_W-1:0] LOWER_A     = 8'h61;
  localparam logic [LABEL_W-1:0] LOWER_Z     = 8'h7a;
  localparam logic [LABEL_W-1:0] CASE_OFFSET = 8'h20;

endpackage

`default_nettype wire

// File: design/bpt_shift.sv
// Position adjust unit for one buffer edit, shared by all stored positions.
// Purely combinational; no package dependencies.
`default_nettype none

module bpt_shift #(
  parameter int POS_BITS = 24
) (
  input  wire logic [POS_BITS-1:0] sh_p,
  input  wire logic [POS_BITS-1:0] sh_at,
  input  wire logic [POS_BITS-1:0] sh_ins,
  input  wire logic [POS_BITS-1:0] sh_del,
  output logic      [POS_BITS-1:0] sh_res,
  output logic                     sh_is_before
);

  logic [POS_BITS:0] at_del;
  logic              past_del;
  logic [POS_BITS:0] moved;

  always_comb begin
    sh_is_before = (sh_at > sh_p);
    at_del       = {1'b0, sh_at} + {1'b0, sh_del};
    past_del     = (at_del <= {1'b0, sh_p});
    // p >= at + del here, so p - del cannot wrap
    moved        = {1'b0, sh_p - sh_del} + {1'b0, sh_ins};
    if (sh_is_before) begin
      sh_res = sh_p;
    end else if (past_del) begin
      sh_res = moved[POS_BITS] ? {POS_BITS{1'b1}} : moved[POS_BITS-1:0];
    end else begin
      sh_res = sh_at;
    end
  end

endmodule

`default_nettype wire

// File: design/bookmark_position_table_core.sv
// Bookmark position table. Add and goto scan the N stored entries through one
// read port, and the result strobe follows the scan. Update runs each entry
// three times through the shared position adjust unit (end, start, cursor).
// An unused command answers in the next cycle. busy is low from the strobe cycle
// on, so the next word may be accepted while the result is on the ports.
// Reset (rst_n, synchronous) empties the table; entry contents are not cleared.
`default_nettype none

`include "bookmark_position_table_core_defines.svh"

module bookmark_position_table_core #(
  parameter int MARK_ENTRIES = bpt_pkg::MARK_ENTRIES_DEF,
  parameter int POS_BITS     = bpt_pkg::POS_BITS_DEF,
  parameter int COL_BITS     = bpt_pkg::COL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bpt_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [bpt_pkg::LABEL_W-1:0]    in_label,
  input  wire logic                           in_extend,
  input  wire logic                           in_cur_selected,
  input  wire logic [POS_BITS-1:0]            in_cur_start,
  input  wire logic [POS_BITS-1:0]            in_cur_end,
  input  wire logic                           in_cur_rect,
  input  wire logic [COL_BITS-1:0]            in_cur_rect_start,
  input  wire logic [COL_BITS-1:0]            in_cur_rect_end,
  input  wire logic [POS_BITS-1:0]            in_position,
  input  wire logic [POS_BITS-1:0]            in_inserted,
  input  wire logic [POS_BITS-1:0]            in_deleted,
  output logic                                out_valid,
  output logic [bpt_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_selected,
  output logic                                out_rectangular,
  output logic [POS_BITS-1:0]                 out_sel_start,
  output logic [POS_BITS-1:0]                 out_sel_end,
  output logic [COL_BITS-1:0]                 out_rect_start,
  output logic [COL_BITS-1:0]                 out_rect_end,
  output logic [POS_BITS-1:0]                 out_cursor_pos
);

  import bpt_pkg::*;

  localparam int IDX_W = (MARK_ENTRIES > 1) ? $clog2(MARK_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MARK_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPD_END,
    S_UPD_START,
    S_UPD_CUR
  } state_t;

  // table storage
  logic [LABEL_W-1:0]  mem_label [MARK_ENTRIES];
  logic                mem_sel   [MARK_ENTRIES];
  logic                mem_rect  [MARK_ENTRIES];
  logic [POS_BITS-1:0] mem_start [MARK_ENTRIES];
  logic [POS_BITS-1:0] mem_end   [MARK_ENTRIES];
  logic [COL_BITS-1:0] mem_rs    [MARK_ENTRIES];
  logic [COL_BITS-1:0] mem_re    [MARK_ENTRIES];
  logic [POS_BITS-1:0] mem_cur   [MARK_ENTRIES];

  // registered read word
  logic [LABEL_W-1:0]  rd_label_r;
  logic                rd_sel_r;
  logic                rd_rect_r;
  logic [POS_BITS-1:0] rd_start_r;
  logic [POS_BITS-1:0] rd_end_r;
  logic [COL_BITS-1:0] rd_rs_r;
  logic [COL_BITS-1:0] rd_re_r;
  logic [POS_BITS-1:0] rd_cur_r;

  // captured command
  logic [CMD_W-1:0]    cmd_r;
  logic [LABEL_W-1:0]  label_r;
  logic                extend_r;
  logic                csel_r;
  logic [POS_BITS-1:0] cstart_r;
  logic [POS_BITS-1:0] cend_r;
  logic                crect_r;
  logic [COL_BITS-1:0] crs_r;
  logic [COL_BITS-1:0] cre_r;
  logic [POS_BITS-1:0] pos_r;
  logic [POS_BITS-1:0] ins_r;
  logic [POS_BITS-1:0] del_r;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                rd_vld_r;
  logic                adj_r, adj_nxt;
  logic [POS_BITS-1:0] new_end_r, new_end_nxt;
  logic [POS_BITS-1:0] new_start_r, new_start_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_sel_r, out_sel_nxt;
  logic                out_rect_r, out_rect_nxt;
  logic [POS_BITS-1:0] out_start_r, out_start_nxt;
  logic [POS_BITS-1:0] out_end_r, out_end_nxt;
  logic [COL_BITS-1:0] out_rs_r, out_rs_nxt;
  logic [COL_BITS-1:0] out_re_r, out_re_nxt;
  logic [POS_BITS-1:0] out_cur_r, out_cur_nxt;

  logic                accept;
  logic [LABEL_W-1:0]  label_fold;
  logic                hit;
  logic                more;
  logic [CNT_W-1:0]    idx_inc;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [LABEL_W-1:0]  wr_label;
  logic                wr_sel;
  logic                wr_rect;
  logic [POS_BITS-1:0] wr_start;
  logic [POS_BITS-1:0] wr_end;
  logic [COL_BITS-1:0] wr_rs;
  logic [COL_BITS-1:0] wr_re;
  logic [POS_BITS-1:0] wr_cur;

  logic [POS_BITS-1:0] sh_p;
  logic [POS_BITS-1:0] sh_res;
  logic                sh_is_before;

  logic [POS_BITS-1:0] ext_os, ext_oe, ext_ns, ext_ne;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign hit     = (state_r == S_SEARCH) && rd_vld_r && (rd_label_r == label_r);
  assign more    = (idx_r < count_r);
  assign idx_inc = idx_r + CNT_W'(1);

  always_comb begin
    label_fold = in_label;
    if (in_label inside {[LOWER_A:LOWER_Z]}) begin
      label_fold = in_label - CASE_OFFSET;
    end
  end

  always_comb begin
    case (state_r)
      S_UPD_END:   sh_p = rd_end_r;
      S_UPD_START: sh_p = rd_start_r;
      default:     sh_p = rd_cur_r;
    endcase
  end

  bpt_shift #(
    .POS_BITS (POS_BITS)
  ) u_shift (
    .sh_p         (sh_p),
    .sh_at        (pos_r),
    .sh_ins       (ins_r),
    .sh_del       (del_r),
    .sh_res       (sh_res),
    .sh_is_before (sh_is_before)
  );

  // extend span: unselected side counts as its cursor
  always_comb begin
    ext_os = csel_r ? cstart_r : pos_r;
    ext_oe = csel_r ? cend_r : pos_r;
    ext_ns = rd_sel_r ? rd_start_r : rd_cur_r;
    ext_ne = rd_sel_r ? rd_end_r : rd_cur_r;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    rd_idx_nxt     = rd_idx_r;
    adj_nxt        = adj_r;
    new_end_nxt    = new_end_r;
    new_start_nxt  = new_start_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx_r[IDX_W-1:0];
    wr_label       = label_r;
    wr_sel         = csel_r;
    wr_rect        = crect_r;
    wr_start       = cstart_r;
    wr_end         = cend_r;
    wr_rs          = crs_r;
    wr_re          = cre_r;
    wr_cur         = pos_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_sel_nxt    = out_sel_r;
    out_rect_nxt   = out_rect_r;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;
    out_rs_nxt     = out_rs_r;
    out_re_nxt     = out_re_r;
    out_cur_nxt    = out_cur_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // default answer: ok with all fields zero
          out_status_nxt = STS_OK;
          out_sel_nxt    = 1'b0;
          out_rect_nxt   = 1'b0;
          out_start_nxt  = '0;
          out_end_nxt    = '0;
          out_rs_nxt     = '0;
          out_re_nxt     = '0;
          out_cur_nxt    = '0;
          idx_nxt        = '0;
          case (in_cmd)
            CMD_ADD, CMD_GOTO: begin
              state_nxt = S_SEARCH;
            end
            CMD_UPDATE: begin
              if (count_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_UPD_END;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (cmd_r == CMD_ADD) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_r;
          end else begin
            out_cur_nxt = rd_cur_r;
            if (extend_r) begin
              out_sel_nxt   = 1'b1;
              out_start_nxt = (ext_os < ext_ns) ? ext_os : ext_ns;
              out_end_nxt   = (ext_oe > ext_ne) ? ext_oe : ext_ne;
            end else if (rd_sel_r) begin
              out_sel_nxt   = 1'b1;
              out_start_nxt = rd_start_r;
              out_end_nxt   = rd_end_r;
              if (rd_rect_r) begin
                out_rect_nxt = 1'b1;
                out_rs_nxt   = rd_rs_r;
                out_re_nxt   = rd_re_r;
              end
            end
          end
        end else if (more) begin
          rd_en      = 1'b1;
          rd_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt    = idx_inc;
        end else begin
          // scan exhausted without a match
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (cmd_r == CMD_ADD) begin
            if (count_r == CNT_W'(MARK_ENTRIES)) begin
              out_status_nxt = STS_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IDX_W-1:0];
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            out_status_nxt = STS_NOT_FOUND;
          end
        end
      end

      S_UPD_END: begin
        // selection moves only if the edit does not lie beyond its end
        adj_nxt     = rd_sel_r && !sh_is_before;
        new_end_nxt = sh_res;
        state_nxt   = S_UPD_START;
      end

      S_UPD_START: begin
        new_start_nxt = sh_res;
        state_nxt     = S_UPD_CUR;
      end

      S_UPD_CUR: begin
        wr_en    = 1'b1;
        wr_addr  = idx_r[IDX_W-1:0];
        wr_label = rd_label_r;
        wr_rect  = rd_rect_r;
        wr_rs    = rd_rs_r;
        wr_re    = rd_re_r;
        wr_cur   = sh_res;
        wr_sel   = adj_r ? (new_end_r > new_start_r) : rd_sel_r;
        wr_start = adj_r ? new_start_r : rd_start_r;
        wr_end   = adj_r ? new_end_r : rd_end_r;
        idx_nxt  = idx_inc;
        if (idx_inc < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = idx_inc[IDX_W-1:0];
          state_nxt = S_UPD_END;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_label[wr_addr] <= wr_label;
      mem_sel[wr_addr]   <= wr_sel;
      mem_rect[wr_addr]  <= wr_rect;
      mem_start[wr_addr] <= wr_start;
      mem_end[wr_addr]   <= wr_end;
      mem_rs[wr_addr]    <= wr_rs;
      mem_re[wr_addr]    <= wr_re;
      mem_cur[wr_addr]   <= wr_cur;
    end
    if (rd_en) begin
      rd_label_r <= mem_label[rd_addr];
      rd_sel_r   <= mem_sel[rd_addr];
      rd_rect_r  <= mem_rect[rd_addr];
      rd_start_r <= mem_start[rd_addr];
      rd_end_r   <= mem_end[rd_addr];
      rd_rs_r    <= mem_rs[rd_addr];
      rd_re_r    <= mem_re[rd_addr];
      rd_cur_r   <= mem_cur[rd_addr];
    end
  end

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      label_r  <= label_fold;
      extend_r <= in_extend;
      csel_r   <= in_cur_selected;
      cstart_r <= in_cur_start;
      cend_r   <= in_cur_end;
      crect_r  <= in_cur_rect;
      crs_r    <= in_cur_rect_start;
      cre_r    <= in_cur_rect_end;
      pos_r    <= in_position;
      ins_r    <= in_inserted;
      del_r    <= in_deleted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    adj_r        <= adj_nxt;
    new_end_r    <= new_end_nxt;
    new_start_r  <= new_start_nxt;
    out_status_r <= out_status_nxt;
    out_sel_r    <= out_sel_nxt;
    out_rect_r   <= out_rect_nxt;
    out_start_r  <= out_start_nxt;
    out_end_r    <= out_end_nxt;
    out_rs_r     <= out_rs_nxt;
    out_re_r     <= out_re_nxt;
    out_cur_r    <= out_cur_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_selected    = out_sel_r;
  assign out_rectangular = out_rect_r;
  assign out_sel_start   = out_start_r;
  assign out_sel_end     = out_end_r;
  assign out_rect_start  = out_rs_r;
  assign out_rect_end    = out_re_r;
  assign out_cursor_pos  = out_cur_r;

  `BPT_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE, "result strobe while busy")
  `BPT_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(MARK_ENTRIES), "entry count overflow")
  `BPT_ASSERT_NEXT(a_accept_work, accept, busy || out_valid_r, "accepted word dropped")
  `BPT_ASSERT_NOW(a_write_busy, wr_en, state_r != S_IDLE, "table write while idle")
  `BPT_ASSERT_NOW(a_full_count, out_valid_r && (out_status_r == STS_FULL),
                  count_r == CNT_W'(MARK_ENTRIES), "full reported with free slot")

endmodule

`default_nettype wire
